### hw/rtl/stq_pkg.sv
// package: types, codes and defaults shared by the sorted timer queue
`default_nettype none
package stq_pkg;

    localparam int TIMERS_DEF     = 8;
    localparam int DELAY_BITS_DEF = 24;
    localparam int TIME_BITS_DEF  = 48;

    localparam int MAX_OUT = 8;
    localparam int BUF_W   = $clog2(MAX_OUT);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_START_ONE = 2'd1;
    localparam logic [1:0] MODE_START_PER = 2'd2;
    localparam logic [1:0] MODE_STOP      = 2'd3;

    localparam logic [1:0] EV_EXPIRE  = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_STOPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  timer_id;
        logic [23:0] delay_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] slot_id;
        logic       was_active;
        logic       last;
    } t_out_word;

endpackage
`default_nettype wire

### hw/rtl/stq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/sorted_timer_queue_core.sv
// top level: sorted timer queue with deadline and period memories
// Usage:
//   Input channel i_in_valid / o_in_stall carries one word: a tick (time
//   advances one millisecond), a one-shot or periodic start, or a stop.
//   Output channel o_out_valid / i_out_stall carries result words: one
//   started/stopped word per command, one expiry word per due slot on a tick
//   (at most eight per tick), last set on the final word of an input.
//   The block works on one input at a time; o_in_stall is high until every
//   result of the current word has been handed to the output register.
//   A start removes the slot, writes its deadline and period, then walks
//   the list, reading one deadline at a time from the deadline ram. A tick
//   checks the head until the list is empty, eight words are buffered or
//   the head is not due, reinserting each due periodic slot by the same
//   walk, then emits its words; a stop removes the slot and emits its word.
//   A start or stop with an out-of-range slot and a tick with nothing due
//   give no word. When the receiver stalls, the output register holds its
//   word and emission waits. Reset clears the time, the queue and the
//   active bits; the rams need no clearing.
`default_nettype none
module sorted_timer_queue_core
    import stq_pkg::*;
#(
    parameter int TIMERS     = TIMERS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);
    localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CMD      = 8'b0000_0010,
        S_LINK_RD  = 8'b0000_0100,
        S_LINK_CMP = 8'b0000_1000,
        S_INSERT   = 8'b0001_0000,
        S_TK_RD    = 8'b0010_0000,
        S_TK_CMP   = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [CW-1:0]         r_len, n_len;
    logic [TIMERS-1:0]     r_active, n_active;
    logic [SW-1:0]         r_order [TIMERS];
    logic [SW-1:0]         n_order [TIMERS];
    logic [1:0]            r_mode, n_mode;
    logic [SW-1:0]         r_sid, n_sid;
    logic [DELAY_BITS-1:0] r_dly, n_dly;
    logic [TIME_BITS-1:0]  r_new_dl, n_new_dl;
    logic [SW-1:0]         r_ins, n_ins;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_tick, n_tick;
    t_out_word             r_buf [MAX_OUT];
    t_out_word             n_buf [MAX_OUT];
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [BUF_W-1:0]      r_ei, n_ei;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic                  in_acc;
    logic                  dl_we, per_we;
    logic [SW-1:0]         ram_waddr, ram_raddr;
    logic [TIME_BITS-1:0]  dl_wdata, dl_rdata;
    logic [DELAY_BITS-1:0] per_wdata, per_rdata;

    logic [SW-1:0]         u_slot;
    logic                  u_found;
    logic [CW-1:0]         u_pos;
    logic [SW-1:0]         u_order [TIMERS];

    stq_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMERS)) u_dl_ram (
        .i_clk  (i_clk),
        .i_we   (dl_we),
        .i_waddr(ram_waddr),
        .i_wdata(dl_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(dl_rdata)
    );

    stq_ram #(.WIDTH(DELAY_BITS), .DEPTH(TIMERS)) u_per_ram (
        .i_clk  (i_clk),
        .i_we   (per_we),
        .i_waddr(ram_waddr),
        .i_wdata(per_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(per_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // removal of one slot from the ordered list
    always_comb begin
        u_slot  = (r_state == S_TK_CMP) ? r_order[0] : r_sid;
        u_found = 1'b0;
        u_pos   = '0;
        for (int i = 0; i < TIMERS; i++) begin
            if (!u_found && (CW'(i) < r_len) && (r_order[i] == u_slot)) begin
                u_found = 1'b1;
                u_pos   = CW'(i);
            end
        end
        u_order = r_order;
        for (int i = 0; i < TIMERS - 1; i++) begin
            if (u_found && (CW'(i) >= u_pos)) begin
                u_order[i] = r_order[i+1];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_len       = r_len;
        n_active    = r_active;
        n_order     = r_order;
        n_mode      = r_mode;
        n_sid       = r_sid;
        n_dly       = r_dly;
        n_new_dl    = r_new_dl;
        n_ins       = r_ins;
        n_idx       = r_idx;
        n_tick      = r_tick;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_ei        = r_ei;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        dl_we       = 1'b0;
        per_we      = 1'b0;
        ram_waddr   = r_sid;
        ram_raddr   = r_order[0];
        dl_wdata    = r_now + TIME_BITS'(r_dly);
        per_wdata   = (r_mode == MODE_START_PER) ? r_dly : '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode = i_in_word.mode;
                    n_sid  = SW'(i_in_word.timer_id);
                    n_dly  = DELAY_BITS'(i_in_word.delay_ms);
                    n_cnt  = '0;
                    n_ei   = '0;
                    if (i_in_word.mode == MODE_TICK) begin
                        n_now   = r_now + TIME_BITS'(1);
                        n_state = S_TK_RD;
                    end else if (32'(i_in_word.timer_id) < TIMERS) begin
                        n_state = S_CMD;
                    end
                end
            end
            S_CMD: begin
                n_order           = u_order;
                if (u_found) begin
                    n_len = r_len - CW'(1);
                end
                n_active[r_sid]   = 1'b0;
                n_buf[0].event_res  = (r_mode == MODE_STOP) ? EV_STOPPED : EV_STARTED;
                n_buf[0].slot_id    = 3'(r_sid);
                n_buf[0].was_active = r_active[r_sid];
                n_buf[0].last       = 1'b0;
                n_cnt             = CNT_W'(1);
                if (r_mode == MODE_STOP) begin
                    n_state = S_EMIT;
                end else begin
                    dl_we    = 1'b1;
                    per_we   = 1'b1;
                    n_new_dl = dl_wdata;
                    n_ins    = r_sid;
                    n_idx    = '0;
                    n_tick   = 1'b0;
                    n_state  = S_LINK_RD;
                end
            end
            S_LINK_RD: begin
                if (r_idx == r_len) begin
                    n_state = S_INSERT;
                end else begin
                    ram_raddr = r_order[r_idx[SW-1:0]];
                    n_state   = S_LINK_CMP;
                end
            end
            S_LINK_CMP: begin
                if (dl_rdata >= r_new_dl) begin
                    n_state = S_INSERT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_LINK_RD;
                end
            end
            S_INSERT: begin
                for (int i = 1; i < TIMERS; i++) begin
                    if (CW'(i) > r_idx) begin
                        n_order[i] = r_order[i-1];
                    end
                end
                n_order[r_idx[SW-1:0]] = r_ins;
                n_len           = r_len + CW'(1);
                n_active[r_ins] = 1'b1;
                n_state         = r_tick ? S_TK_RD : S_EMIT;
            end
            S_TK_RD: begin
                if ((r_cnt == CNT_W'(MAX_OUT)) || (r_len == '0)) begin
                    n_state = (r_cnt == '0) ? S_IDLE : S_EMIT;
                end else begin
                    n_state = S_TK_CMP;
                end
            end
            S_TK_CMP: begin
                if (dl_rdata > r_now) begin
                    n_state = (r_cnt == '0) ? S_IDLE : S_EMIT;
                end else begin
                    n_order                = u_order;
                    n_len                  = r_len - CW'(1);
                    n_active[r_order[0]]   = 1'b0;
                    n_buf[r_cnt[BUF_W-1:0]].event_res  = EV_EXPIRE;
                    n_buf[r_cnt[BUF_W-1:0]].slot_id    = 3'(r_order[0]);
                    n_buf[r_cnt[BUF_W-1:0]].was_active = 1'b1;
                    n_buf[r_cnt[BUF_W-1:0]].last       = 1'b0;
                    n_cnt                  = r_cnt + CNT_W'(1);
                    if (per_rdata != '0) begin
                        dl_we     = 1'b1;
                        ram_waddr = r_order[0];
                        dl_wdata  = dl_rdata + TIME_BITS'(per_rdata);
                        n_new_dl  = dl_wdata;
                        n_ins     = r_order[0];
                        n_idx     = '0;
                        n_tick    = 1'b1;
                        n_state   = S_LINK_RD;
                    end else begin
                        n_state = S_TK_RD;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_buf[r_ei];
                    n_out.last  = ({1'b0, r_ei} == (r_cnt - CNT_W'(1)));
                    n_out_valid = 1'b1;
                    if (n_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ei = r_ei + BUF_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_len       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_len       <= n_len;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order  <= n_order;
        r_mode   <= n_mode;
        r_sid    <= n_sid;
        r_dly    <= n_dly;
        r_new_dl <= n_new_dl;
        r_ins    <= n_ins;
        r_idx    <= n_idx;
        r_tick   <= n_tick;
        r_buf    <= n_buf;
        r_cnt    <= n_cnt;
        r_ei     <= n_ei;
        r_out    <= n_out;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= TIMERS)
        else $error("list length beyond slot count");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == 32'(r_len))
        else $error("active bits disagree with list length");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emit with no buffered word");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (32'(r_len) < TIMERS))
        else $error("insert into full list");

endmodule
`default_nettype wire

### dv/tb.sv
// testbench for the sorted timer queue: queued stimulus, in-bench queue model, result checks
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import stq_pkg::*;

    localparam int NSLOT = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_AT = 220;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    sorted_timer_queue_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

    always #1 i_clk = ~i_clk;

    // queue model
    logic [47:0] now_ms;
    logic [47:0] slot_deadline [NSLOT];
    logic [23:0] slot_period [NSLOT];
    logic        slot_queued [NSLOT];
    logic [2:0]  run_order [NSLOT];
    int          run_len;

    t_in_word  cmd_queue [$];
    t_out_word result_queue [$];
    int        errors = 0;
    int        words_in = 0;
    int        words_out = 0;
    int        expiries = 0;
    int        idle_cycles = 0;

    task automatic report(input string what, input t_out_word got, input t_out_word want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void unlink_slot(input int s);
        int pos;
        pos = run_len;
        for (int i = 0; i < run_len; i++)
            if (run_order[i] == s && pos == run_len) pos = i;
        if (pos < run_len) begin
            for (int i = pos; i + 1 < run_len; i++) run_order[i] = run_order[i+1];
            run_len--;
        end
        slot_queued[s] = 0;
    endfunction

    function automatic void link_slot(input int s);
        int pos;
        pos = run_len;
        if (slot_queued[s] || run_len >= NSLOT) return;
        for (int i = 0; i < run_len; i++)
            if (slot_deadline[run_order[i]] >= slot_deadline[s] && pos == run_len) pos = i;
        for (int i = run_len; i > pos; i--) run_order[i] = run_order[i-1];
        run_order[pos] = 3'(s);
        run_len++;
        slot_queued[s] = 1;
    endfunction

    function automatic void predict_queue(input t_in_word w);
        t_out_word r;
        int n;
        int s;
        logic was;
        n = 0;
        if (w.mode == MODE_TICK) begin
            now_ms = now_ms + 48'd1;
            while (n < MAX_OUT && run_len > 0) begin
                s = run_order[0];
                if (slot_deadline[s] > now_ms) break;
                unlink_slot(s);
                r.event_res = EV_EXPIRE;
                r.slot_id = 3'(s);
                r.was_active = 1'b1;
                r.last = 1'b0;
                result_queue.push_back(r);
                n++;
                if (slot_period[s] != 0) begin
                    slot_deadline[s] = slot_deadline[s] + 48'(slot_period[s]);
                    link_slot(s);
                end
            end
            if (n > 0) result_queue[$].last = 1'b1;
        end else begin
            s = w.timer_id;
            was = slot_queued[s];
            unlink_slot(s);
            if (w.mode == MODE_STOP) begin
                r.event_res = EV_STOPPED;
            end else begin
                slot_deadline[s] = now_ms + 48'(w.delay_ms);
                slot_period[s] = (w.mode == MODE_START_PER) ? w.delay_ms : 24'd0;
                link_slot(s);
                r.event_res = EV_STARTED;
            end
            r.slot_id = 3'(s);
            r.was_active = was;
            r.last = 1'b1;
            result_queue.push_back(r);
        end
    endfunction

    function automatic t_in_word mk(input logic [1:0] m, input int id, input logic [23:0] d);
        t_in_word w;
        w.mode = m;
        w.timer_id = 3'(id);
        w.delay_ms = d;
        return w;
    endfunction

    function automatic logic [23:0] rand_delay();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'hFFFFFF;
            2: return 24'd0;
            default: return 24'($urandom_range(0, 12));
        endcase
    endfunction

    // driver
    int in_gap = 0;
    int words_sent = 0;
    int out_gap = 0;
    int out_seen = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid) begin
            if (words_in == words_sent) begin
                i_in_valid <= 1'b0;
                in_gap = $urandom_range(0, 10);
            end
        end else if (in_gap > 0) begin
            in_gap--;
        end else if (cmd_queue.size() > 0
                     && !(words_sent == DRAIN_AT && result_queue.size() > 0)) begin
            i_in_word <= cmd_queue.pop_front();
            i_in_valid <= 1'b1;
            words_sent++;
        end
        if (words_out != out_seen) begin
            out_seen = words_out;
            out_gap = $urandom_range(0, 10);
        end
        if (out_gap > 0) begin
            i_out_stall <= 1'b1;
            out_gap--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && !o_in_stall) begin
                predict_queue(i_in_word);
                words_in++;
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                words_out++;
                if (o_out_word.event_res == EV_EXPIRE) expiries++;
                if (result_queue.size() == 0) begin
                    report("unexpected word", o_out_word, '0);
                end else begin
                    if (o_out_word.event_res != result_queue[0].event_res)
                        report("event_res", o_out_word, result_queue[0]);
                    else if (o_out_word.slot_id != result_queue[0].slot_id)
                        report("slot_id", o_out_word, result_queue[0]);
                    else if (o_out_word.was_active != result_queue[0].was_active)
                        report("was_active", o_out_word, result_queue[0]);
                    else if (o_out_word.last != result_queue[0].last)
                        report("last", o_out_word, result_queue[0]);
                    void'(result_queue.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress");
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int id;
        now_ms = '0;
        run_len = 0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_queued[i] = 0;
            slot_deadline[i] = '0;
            slot_period[i] = '0;
            run_order[i] = '0;
        end
        // directed: fill every slot, stop idle/active, extremes, period zero
        for (int i = 0; i < NSLOT; i++) cmd_queue.push_back(mk(MODE_START_ONE, i, 24'd1));
        cmd_queue.push_back(mk(MODE_TICK, 0, 24'hFFFFFF));
        cmd_queue.push_back(mk(MODE_STOP, 7, 24'd0));
        cmd_queue.push_back(mk(MODE_START_PER, 2, 24'd0));
        cmd_queue.push_back(mk(MODE_START_PER, 3, 24'd2));
        cmd_queue.push_back(mk(MODE_START_ONE, 5, 24'hFFFFFF));
        cmd_queue.push_back(mk(MODE_STOP, 5, 24'hFFFFFF));
        cmd_queue.push_back(mk(MODE_START_PER, 6, 24'hFFFFFF));
        cmd_queue.push_back(mk(MODE_TICK, 0, 24'd0));
        cmd_queue.push_back(mk(MODE_TICK, 0, 24'd0));
        cmd_queue.push_back(mk(MODE_TICK, 0, 24'd0));
        cmd_queue.push_back(mk(MODE_START_PER, 3, 24'd1));
        cmd_queue.push_back(mk(MODE_TICK, 0, 24'd0));
        cmd_queue.push_back(mk(MODE_STOP, 3, 24'd0));
        // random: mostly starts with short delays and ticks
        for (int k = 0; k < 410; k++) begin
            id = $urandom_range(0, NSLOT - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cmd_queue.push_back(mk(MODE_TICK, id, 24'($urandom)));
                4, 5: cmd_queue.push_back(mk(MODE_START_ONE, id, rand_delay()));
                6, 7: cmd_queue.push_back(mk(MODE_START_PER, id, rand_delay()));
                default: cmd_queue.push_back(mk(MODE_STOP, id, 24'($urandom)));
            endcase
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (cmd_queue.size() == 0 && !i_in_valid);
        wait (result_queue.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("run: %0d input words, %0d result words, %0d expiries", words_in, words_out,
                 expiries);
        $display("covered full list, stops, periodic reinserts, one drain pause, random stalls");
        if (errors == 0 && result_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words outstanding", errors, result_queue.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
